@@ sv/mbim_pkg.sv @@
package mbim_pkg;

	localparam int CmdDepthDefault = 2;
	localparam int ResDepthDefault = 2;

	localparam logic [15:0] ADDR_MASK       = 16'hE001;
	localparam logic [15:0] ADDR_SELECT     = 16'h8000;
	localparam logic [15:0] ADDR_BANK_DATA  = 16'h8001;
	localparam logic [15:0] ADDR_MIRROR     = 16'hA000;
	localparam logic [15:0] ADDR_IRQ_COUNT  = 16'hC000;
	localparam logic [15:0] ADDR_IRQ_RELOAD = 16'hC001;
	localparam logic [15:0] ADDR_IRQ_OFF    = 16'hE000;
	localparam logic [15:0] ADDR_IRQ_ON     = 16'hE001;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic [7:0] CFG_BANK_COUNT  = 8'd0;
	localparam logic [7:0] CFG_FOUR_SCREEN = 8'd1;

	localparam logic [2:0] SEL_OUTER = 3'd0;
	localparam logic [2:0] SEL_PRG6  = 3'd6;
	localparam logic [2:0] SEL_PRG7  = 3'd7;

	localparam logic [7:0] UPPER_C_BASE = 8'h3E;
	localparam logic [7:0] UPPER_E_BASE = 8'h3F;
	localparam logic [7:0] RESET_BANK_COUNT = 8'd32;
	localparam logic [7:0] RESET_PRG_HIGH   = 8'd1;

	localparam logic [1:0] MIRROR_NONE = 2'd0;
	localparam logic [1:0] MIRROR_VERT = 2'd1;
	localparam logic [1:0] MIRROR_HORZ = 2'd2;

	typedef logic [3:0] cmd_kind_t;

	localparam cmd_kind_t CMD_NONE       = 4'd0;
	localparam cmd_kind_t CMD_SELECT     = 4'd1;
	localparam cmd_kind_t CMD_BANK       = 4'd2;
	localparam cmd_kind_t CMD_MIRROR     = 4'd3;
	localparam cmd_kind_t CMD_IRQ_COUNT  = 4'd4;
	localparam cmd_kind_t CMD_IRQ_RELOAD = 4'd5;
	localparam cmd_kind_t CMD_IRQ_OFF    = 4'd6;
	localparam cmd_kind_t CMD_IRQ_ON     = 4'd7;
	localparam cmd_kind_t CMD_TICK       = 4'd8;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic [7:0] bank_window_8000;
		logic [7:0] bank_window_a000;
		logic [7:0] bank_window_c000;
		logic [7:0] bank_window_e000;
		logic [1:0] mirroring;
		logic       irq_line;
	} res_t;

	function automatic logic [7:0] last_bank(input logic [7:0] count);
		return {count[6:0], 1'b0} - 8'd1;
	endfunction

endpackage

@@ sv/mmc3_like_bank_irq_mapper.sv @@
// Channel   Handshake           Payload
// input     push / full         opcode, cpu_address, write_data, in_vblank
// result    empty / pop         bank_window_8000/a000/c000/e000, mirroring, irq_line
// config    cfg_valid/cfg_ready cfg_index, cfg_data
//
// One request per cycle is sustained while the result side keeps popping; each request yields one result.
// An accepted request waits in the command queue until the back end takes it, which it does
// only while the result queue has room, and writes its result into the result queue.
// Stalls on the result side fill the result queue, then the command queue,
// and only then raise full. Reset is asynchronous and leaves both queues empty.
// A configuration write waits while the command queue still holds a request.
module mmc3_like_bank_irq_mapper #(
	parameter int CMD_DEPTH = mbim_pkg::CmdDepthDefault,
	parameter int RES_DEPTH = mbim_pkg::ResDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        opcode,
	input  logic [15:0] cpu_address,
	input  logic [7:0]  write_data,
	input  logic        in_vblank,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  bank_window_8000,
	output logic [7:0]  bank_window_a000,
	output logic [7:0]  bank_window_c000,
	output logic [7:0]  bank_window_e000,
	output logic [1:0]  mirroring,
	output logic        irq_line,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import mbim_pkg::*;

	cmd_t cmd;
	logic cmd_empty;
	logic cmd_pop;
	res_t res;

	assign cfg_ready = cmd_empty;

	mbim_front #(
		.CMD_DEPTH(CMD_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.opcode     (opcode),
		.cpu_address(cpu_address),
		.write_data (write_data),
		.in_vblank  (in_vblank),
		.cmd_pop    (cmd_pop),
		.cmd        (cmd),
		.cmd_empty  (cmd_empty)
	);

	mbim_back #(
		.RES_DEPTH(RES_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.cfg_write(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pop      (pop),
		.res      (res),
		.empty    (empty)
	);

	assign bank_window_8000 = res.bank_window_8000;
	assign bank_window_a000 = res.bank_window_a000;
	assign bank_window_c000 = res.bank_window_c000;
	assign bank_window_e000 = res.bank_window_e000;
	assign mirroring        = res.mirroring;
	assign irq_line         = res.irq_line;

endmodule

@@ sv/mbim_fifo.sv @@
module mbim_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/mbim_front.sv @@
module mbim_front #(
	parameter int CMD_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic          opcode,
	input  logic [15:0]   cpu_address,
	input  logic [7:0]    write_data,
	input  logic          in_vblank,
	input  logic          cmd_pop,
	output mbim_pkg::cmd_t cmd,
	output logic          cmd_empty
);
	import mbim_pkg::*;

	cmd_t        cmd_d;
	logic [15:0] addr_dec;

	assign addr_dec = cpu_address & ADDR_MASK;

	always_comb begin
		cmd_d.data = write_data;
		cmd_d.kind = CMD_NONE;
		if (opcode == OP_TICK) begin
			if (!in_vblank) begin
				cmd_d.kind = CMD_TICK;
			end
		end else begin
			case (addr_dec)
				ADDR_SELECT:     cmd_d.kind = CMD_SELECT;
				ADDR_BANK_DATA:  cmd_d.kind = CMD_BANK;
				ADDR_MIRROR:     cmd_d.kind = CMD_MIRROR;
				ADDR_IRQ_COUNT:  cmd_d.kind = CMD_IRQ_COUNT;
				ADDR_IRQ_RELOAD: cmd_d.kind = CMD_IRQ_RELOAD;
				ADDR_IRQ_OFF:    cmd_d.kind = CMD_IRQ_OFF;
				ADDR_IRQ_ON:     cmd_d.kind = CMD_IRQ_ON;
				default:         cmd_d.kind = CMD_NONE;
			endcase
		end
	end

	mbim_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cmd_d),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd),
		.empty (cmd_empty)
	);

endmodule

@@ sv/mbim_back.sv @@
module mbim_back #(
	parameter int RES_DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mbim_pkg::cmd_t cmd,
	input  logic           cmd_empty,
	output logic           cmd_pop,
	input  logic           cfg_write,
	input  logic [7:0]     cfg_index,
	input  logic [7:0]     cfg_data,
	input  logic           pop,
	output mbim_pkg::res_t res,
	output logic           empty
);
	import mbim_pkg::*;

	logic       four_screen_q;
	logic [2:0] select_q,   select_d;
	logic [7:0] prg_low_q,  prg_low_d;
	logic [7:0] prg_high_q, prg_high_d;
	logic [7:0] outer_q,    outer_d;
	logic [7:0] upper_c_q,  upper_c_d;
	logic [7:0] upper_e_q,  upper_e_d;
	logic [1:0] mirror_q,   mirror_d;
	logic       irq_en_q,   irq_en_d;
	logic [7:0] irq_cnt_q,  irq_cnt_d;
	logic [7:0] irq_rld_q,  irq_rld_d;
	logic       irq_pend_q, irq_pend_d;
	logic       res_full;
	logic [7:0] cfg_last;
	res_t       res_d;

	assign cmd_pop  = !cmd_empty && !res_full;
	assign cfg_last = last_bank(cfg_data);

	always_comb begin
		select_d   = select_q;
		prg_low_d  = prg_low_q;
		prg_high_d = prg_high_q;
		outer_d    = outer_q;
		upper_c_d  = upper_c_q;
		upper_e_d  = upper_e_q;
		mirror_d   = mirror_q;
		irq_en_d   = irq_en_q;
		irq_cnt_d  = irq_cnt_q;
		irq_rld_d  = irq_rld_q;
		irq_pend_d = irq_pend_q;
		case (cmd.kind)
			CMD_SELECT: begin
				select_d = cmd.data[2:0];
			end
			CMD_BANK: begin
				if (select_q == SEL_OUTER) begin
					outer_d   = {1'b0, cmd.data[1], 6'b0};
					upper_c_d = UPPER_C_BASE | outer_d;
					upper_e_d = UPPER_E_BASE | outer_d;
				end else if (select_q == SEL_PRG6) begin
					prg_low_d = cmd.data;
				end else if (select_q == SEL_PRG7) begin
					prg_high_d = cmd.data;
				end
			end
			CMD_MIRROR: begin
				if (!four_screen_q) begin
					mirror_d = cmd.data[0] ? MIRROR_HORZ : MIRROR_VERT;
				end
			end
			CMD_IRQ_COUNT: begin
				irq_cnt_d  = cmd.data;
				irq_pend_d = 1'b0;
			end
			CMD_IRQ_RELOAD: begin
				irq_rld_d  = cmd.data;
				irq_pend_d = 1'b0;
			end
			CMD_IRQ_OFF: begin
				irq_en_d   = 1'b0;
				irq_pend_d = 1'b0;
			end
			CMD_IRQ_ON: begin
				irq_en_d   = 1'b1;
				irq_pend_d = 1'b0;
			end
			CMD_TICK: begin
				if (irq_en_q && !irq_pend_q) begin
					if (irq_cnt_q == '0) begin
						irq_pend_d = 1'b1;
						irq_cnt_d  = irq_rld_q;
					end else begin
						irq_cnt_d = irq_cnt_q - 8'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_d.bank_window_8000 = prg_low_d | outer_d;
		res_d.bank_window_a000 = prg_high_d | outer_d;
		res_d.bank_window_c000 = upper_c_d;
		res_d.bank_window_e000 = upper_e_d;
		res_d.mirroring        = mirror_d;
		res_d.irq_line         = irq_pend_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_screen_q <= 1'b0;
			select_q      <= '0;
			prg_low_q     <= '0;
			prg_high_q    <= RESET_PRG_HIGH;
			outer_q       <= '0;
			upper_c_q     <= last_bank(RESET_BANK_COUNT) - 8'd1;
			upper_e_q     <= last_bank(RESET_BANK_COUNT);
			mirror_q      <= MIRROR_NONE;
			irq_en_q      <= 1'b0;
			irq_cnt_q     <= '0;
			irq_rld_q     <= '0;
			irq_pend_q    <= 1'b0;
		end else if (cfg_write) begin
			if (cfg_index == CFG_BANK_COUNT) begin
				upper_c_q    <= cfg_last - 8'd1;
				upper_e_q    <= cfg_last;
			end else if (cfg_index == CFG_FOUR_SCREEN) begin
				four_screen_q <= cfg_data[0];
			end
		end else if (cmd_pop) begin
			select_q   <= select_d;
			prg_low_q  <= prg_low_d;
			prg_high_q <= prg_high_d;
			outer_q    <= outer_d;
			upper_c_q  <= upper_c_d;
			upper_e_q  <= upper_e_d;
			mirror_q   <= mirror_d;
			irq_en_q   <= irq_en_d;
			irq_cnt_q  <= irq_cnt_d;
			irq_rld_q  <= irq_rld_d;
			irq_pend_q <= irq_pend_d;
		end
	end

	mbim_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_pop),
		.wdata (res_d),
		.full  (res_full),
		.pop   (pop),
		.rdata (res),
		.empty (empty)
	);

endmodule

@@ dv/mapper_window_checker.sv @@
module mapper_window_checker
	import mbim_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        opcode,
	input  logic [15:0] cpu_address,
	input  logic [7:0]  write_data,
	input  logic        in_vblank,
	input  logic        empty,
	input  logic        pop,
	input  logic [7:0]  bank_window_8000,
	input  logic [7:0]  bank_window_a000,
	input  logic [7:0]  bank_window_c000,
	input  logic [7:0]  bank_window_e000,
	input  logic [1:0]  mirroring,
	input  logic        irq_line,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          backlog,
	output int          fail_count
);

	logic [7:0] bank_count;
	logic       four_scr;
	logic [2:0] sel;
	logic [7:0] prg_low;
	logic [7:0] prg_high;
	logic [7:0] outer;
	logic [7:0] win_c;
	logic [7:0] win_e;
	logic [1:0] mirror;
	logic       irq_en;
	logic       irq_pend;
	logic [7:0] irq_cnt;
	logic [7:0] irq_rel;
	res_t       expected_windows[$];
	res_t       want;

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp_v);
		if (got !== exp_v) begin
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, exp_v));
		end
	endtask

	task automatic reload_upper();
		logic [7:0] lastb;
		lastb = bank_count + bank_count - 8'd1;
		win_c = lastb - 8'd1;
		win_e = lastb;
	endtask

	task automatic advance_mapper(input logic op, input logic [15:0] addr, input logic [7:0] d,
			input logic vb);
		if (op == OP_TICK) begin
			if (!vb && irq_en && !irq_pend) begin
				if (irq_cnt == 8'd0) begin
					irq_pend = 1'b1;
					irq_cnt = irq_rel;
				end else begin
					irq_cnt = irq_cnt - 8'd1;
				end
			end
		end else begin
			case (addr & ADDR_MASK)
				ADDR_SELECT: begin
					sel = d[2:0];
				end
				ADDR_BANK_DATA: begin
					if (sel == SEL_OUTER) begin
						outer = {1'b0, d[1], 6'b0};
						win_c = UPPER_C_BASE | outer;
						win_e = UPPER_E_BASE | outer;
					end else if (sel == SEL_PRG6) begin
						prg_low = d;
					end else if (sel == SEL_PRG7) begin
						prg_high = d;
					end
				end
				ADDR_MIRROR: begin
					if (!four_scr) begin
						mirror = d[0] ? MIRROR_HORZ : MIRROR_VERT;
					end
				end
				ADDR_IRQ_COUNT: begin
					irq_cnt = d;
					irq_pend = 1'b0;
				end
				ADDR_IRQ_RELOAD: begin
					irq_rel = d;
					irq_pend = 1'b0;
				end
				ADDR_IRQ_OFF: begin
					irq_en = 1'b0;
					irq_pend = 1'b0;
				end
				ADDR_IRQ_ON: begin
					irq_en = 1'b1;
					irq_pend = 1'b0;
				end
				default: begin
				end
			endcase
		end
	endtask

	function automatic res_t current_windows();
		res_t r;
		r.bank_window_8000 = prg_low | outer;
		r.bank_window_a000 = prg_high | outer;
		r.bank_window_c000 = win_c;
		r.bank_window_e000 = win_e;
		r.mirroring = mirror;
		r.irq_line = irq_pend;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_count = RESET_BANK_COUNT;
			four_scr = 1'b0;
			sel = 3'd0;
			prg_low = 8'd0;
			prg_high = RESET_PRG_HIGH;
			outer = 8'd0;
			reload_upper();
			mirror = MIRROR_NONE;
			irq_en = 1'b0;
			irq_pend = 1'b0;
			irq_cnt = 8'd0;
			irq_rel = 8'd0;
			expected_windows.delete();
			backlog <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_BANK_COUNT) begin
					bank_count = cfg_data;
					reload_upper();
				end else if (cfg_index == CFG_FOUR_SCREEN) begin
					four_scr = cfg_data[0];
				end
			end
			if (pop && !empty) begin
				if (expected_windows.size() == 0) begin
					report_mismatch("result popped with no request waiting");
				end else begin
					want = expected_windows.pop_front();
					check_field("bank_window_8000", bank_window_8000, want.bank_window_8000);
					check_field("bank_window_a000", bank_window_a000, want.bank_window_a000);
					check_field("bank_window_c000", bank_window_c000, want.bank_window_c000);
					check_field("bank_window_e000", bank_window_e000, want.bank_window_e000);
					check_field("mirroring", 8'(mirroring), 8'(want.mirroring));
					check_field("irq_line", 8'(irq_line), 8'(want.irq_line));
				end
			end
			if (push && !full) begin
				advance_mapper(opcode, cpu_address, write_data, in_vblank);
				expected_windows.push_back(current_windows());
			end
			backlog <= expected_windows.size();
		end
	end

endmodule

@@ dv/mmc3_like_bank_irq_mapper_tb.sv @@
module mmc3_like_bank_irq_mapper_tb;
	import mbim_pkg::*;

	localparam int StallLimit = 2000;
	localparam int LongHold = 300;
	localparam int PhaseItems = 200;
	localparam int RX_FREE = 0;
	localparam int RX_RANDOM = 1;
	localparam int RX_PATTERN = 2;
	localparam int RX_SLOW = 3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        opcode = OP_WRITE;
	logic [15:0] cpu_address = 16'h0000;
	logic [7:0]  write_data = 8'h00;
	logic        in_vblank = 1'b0;
	logic        pop = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [7:0]  cfg_index = CFG_BANK_COUNT;
	logic [7:0]  cfg_data = 8'h00;
	logic        full;
	logic        empty;
	logic        cfg_ready;
	logic [7:0]  bank_window_8000;
	logic [7:0]  bank_window_a000;
	logic [7:0]  bank_window_c000;
	logic [7:0]  bank_window_e000;
	logic [1:0]  mirroring;
	logic        irq_line;
	int          backlog;
	int          fail_count;

	logic        hold_go = 1'b0;
	int          hold_left = 0;
	int          rx_mode = RX_FREE;
	logic [15:0] rx_mask = 16'hA5A5;
	int          idle_cycles = 0;

	int phase_count [7] = '{1, 128, 0, 255, 200, 64, 32};
	int phase_four [7] = '{1, 0, 1, 0, 2, 255, 0};
	int phase_gap [7] = '{0, 8, 3, 20, 5, 0, 10};
	int phase_rx [7] = '{RX_RANDOM, RX_PATTERN, RX_RANDOM, RX_SLOW, RX_PATTERN, RX_FREE, RX_FREE};

	mmc3_like_bank_irq_mapper uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.opcode(opcode),
		.cpu_address(cpu_address),
		.write_data(write_data),
		.in_vblank(in_vblank),
		.empty(empty),
		.pop(pop),
		.bank_window_8000(bank_window_8000),
		.bank_window_a000(bank_window_a000),
		.bank_window_c000(bank_window_c000),
		.bank_window_e000(bank_window_e000),
		.mirroring(mirroring),
		.irq_line(irq_line),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	mapper_window_checker window_check (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.opcode(opcode),
		.cpu_address(cpu_address),
		.write_data(write_data),
		.in_vblank(in_vblank),
		.empty(empty),
		.pop(pop),
		.bank_window_8000(bank_window_8000),
		.bank_window_a000(bank_window_a000),
		.bank_window_c000(bank_window_c000),
		.bank_window_e000(bank_window_e000),
		.mirroring(mirroring),
		.irq_line(irq_line),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.backlog(backlog),
		.fail_count(fail_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			pop <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_go) begin
			pop <= 1'b0;
			hold_left <= LongHold;
		end else begin
			if ($urandom_range(0, 63) == 0) begin
				rx_mask <= 16'($urandom) | 16'h0001;
			end else begin
				rx_mask <= {rx_mask[0], rx_mask[15:1]};
			end
			case (rx_mode)
				RX_FREE: pop <= 1'b1;
				RX_RANDOM: pop <= ($urandom_range(0, 3) != 0);
				RX_PATTERN: pop <= rx_mask[0];
				default: pop <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= StallLimit) begin
			$display("mmc3_like_bank_irq_mapper_tb failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_item(input logic op, input logic [15:0] addr, input logic [7:0] d,
			input logic vb);
		push <= 1'b1;
		opcode <= op;
		cpu_address <= addr;
		write_data <= d;
		in_vblank <= vb;
		do @(posedge clk); while (full);
	endtask

	task automatic send_random_item();
		logic [15:0] addr;
		logic [15:0] base;
		logic [7:0]  d;
		int          pick;
		pick = $urandom_range(0, 99);
		addr = 16'($urandom);
		d = 8'($urandom);
		if (pick < 30) begin
			send_item(OP_TICK, addr, d, $urandom_range(0, 3) == 0);
		end else if (pick < 90) begin
			case ($urandom_range(0, 6))
				0: base = ADDR_SELECT;
				1: base = ADDR_BANK_DATA;
				2: base = ADDR_MIRROR;
				3: base = ADDR_IRQ_COUNT;
				4: base = ADDR_IRQ_RELOAD;
				5: base = ADDR_IRQ_OFF;
				default: base = ADDR_IRQ_ON;
			endcase
			if (base == ADDR_SELECT && $urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 2))
					0: d[2:0] = SEL_OUTER;
					1: d[2:0] = SEL_PRG6;
					default: d[2:0] = SEL_PRG7;
				endcase
			end
			if ((base == ADDR_IRQ_COUNT || base == ADDR_IRQ_RELOAD) && $urandom_range(0, 3) != 0) begin
				d = 8'($urandom_range(0, 3));
			end
			send_item(OP_WRITE, base | (addr & ~ADDR_MASK), d, $urandom_range(0, 1) == 0);
		end else begin
			send_item(OP_WRITE, addr, d, $urandom_range(0, 1) == 0);
		end
	endtask

	task automatic run_traffic(input int count, input int gap_max);
		int sent;
		int burst;
		int gap;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 30);
			for (int i = 0; i < burst && sent < count; i++) begin
				send_random_item();
				sent++;
			end
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		push <= 1'b0;
	endtask

	task automatic drain();
		do @(posedge clk); while (backlog != 0);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input logic [7:0] count, input logic [7:0] four);
		write_reg(CFG_BANK_COUNT, count);
		write_reg(CFG_FOUR_SCREEN, four);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_directed();
		send_item(OP_TICK, 16'hFFFF, 8'hFF, 1'b1);
		send_item(OP_WRITE, ADDR_SELECT, 8'hFF, 1'b1);
		send_item(OP_WRITE, 16'h9FFF, 8'hFF, 1'b0);
		send_item(OP_WRITE, ADDR_SELECT, 8'h06, 1'b0);
		send_item(OP_WRITE, ADDR_BANK_DATA, 8'h80, 1'b0);
		send_item(OP_WRITE, ADDR_SELECT, 8'hF8, 1'b0);
		send_item(OP_WRITE, ADDR_BANK_DATA, 8'h02, 1'b0);
		send_item(OP_WRITE, ADDR_BANK_DATA, 8'hFD, 1'b0);
		send_item(OP_WRITE, ADDR_SELECT, 8'h03, 1'b0);
		send_item(OP_WRITE, ADDR_BANK_DATA, 8'hFF, 1'b0);
		send_item(OP_WRITE, ADDR_MIRROR, 8'h01, 1'b0);
		send_item(OP_WRITE, 16'hBFFE, 8'hFE, 1'b0);
		send_item(OP_WRITE, 16'hA001, 8'hFF, 1'b0);
		send_item(OP_WRITE, 16'h0000, 8'hFF, 1'b0);
		send_item(OP_WRITE, ADDR_IRQ_COUNT, 8'h02, 1'b0);
		send_item(OP_WRITE, ADDR_IRQ_RELOAD, 8'h00, 1'b0);
		send_item(OP_WRITE, ADDR_IRQ_ON, 8'h00, 1'b0);
		send_item(OP_TICK, 16'h0000, 8'h00, 1'b1);
		send_item(OP_TICK, 16'h0000, 8'h00, 1'b0);
		send_item(OP_TICK, 16'h0000, 8'h00, 1'b0);
		send_item(OP_TICK, 16'h0000, 8'h00, 1'b0);
		send_item(OP_TICK, 16'h0000, 8'h00, 1'b0);
		send_item(OP_WRITE, ADDR_IRQ_OFF, 8'h00, 1'b0);
		send_item(OP_WRITE, 16'hFFFF, 8'h00, 1'b0);
		send_item(OP_TICK, 16'hFFFF, 8'hFF, 1'b0);
		send_item(OP_WRITE, ADDR_IRQ_COUNT, 8'hFF, 1'b0);
		push <= 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		drain();
		for (int p = 0; p < 7; p++) begin
			set_config(8'(phase_count[p]), 8'(phase_four[p]));
			rx_mode <= phase_rx[p];
			if (p == 2) begin
				hold_go <= 1'b1;
				@(posedge clk);
				hold_go <= 1'b0;
			end
			if (p == 4) begin
				run_traffic(PhaseItems / 2, phase_gap[p]);
				drain();
				run_traffic(PhaseItems / 2, phase_gap[p]);
			end else begin
				run_traffic(PhaseItems, phase_gap[p]);
			end
			drain();
		end
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("mmc3_like_bank_irq_mapper_tb passed");
		end else begin
			$display("mmc3_like_bank_irq_mapper_tb failed");
		end
		$finish;
	end

endmodule
